// ----- src/retroactive_stack_timeline_defines.svh -----
// Assertion macros for the retroactive stack timeline
`ifndef RETROACTIVE_STACK_TIMELINE_DEFINES_SVH
`define RETROACTIVE_STACK_TIMELINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RSTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RSTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rstl_pkg.sv -----
package rstl_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [15:0] stamp;
    logic        is_pop;
    logic [31:0] value;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_SCAN,
    S_DEL_RD,
    S_DEL_SCAN,
    S_REP_RD,
    S_REP_SCAN,
    S_EMIT_RD,
    S_EMIT_WAIT,
    S_RESULT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_INS_INIT,
    DP_INS_STEP,
    DP_DEL_INIT,
    DP_DEL_STEP,
    DP_REP_INIT,
    DP_REP_STEP,
    DP_EMIT_LOAD,
    DP_RES_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic ins_stop;
    logic scan_end;
    logic top_zero;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

// ----- src/rstl_ifs.sv -----
interface rstl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [15:0]        stamp;
  logic               is_pop;
  logic signed [31:0] push_value;

  modport source (output valid, output opcode, output stamp, output is_pop,
                  output push_value, input ready);
  modport sink (input valid, input opcode, input stamp, input is_pop,
                input push_value, output ready);
endinterface

interface rstl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] stack_value;
  logic               last;
  logic               empty_res;
  logic [1:0]         status;

  modport source (output valid, output stack_value, output last, output empty_res,
                  output status, input ready);
  modport sink (input valid, input stack_value, input last, input empty_res,
                input status, output ready);
endinterface

// ----- src/retroactive_stack_timeline.sv -----
// Insert: the table is walked down from the top before the status item; a full table skips the walk.
// Delete: one table entry read and shifted per cycle, then the status item.
// Report: the table is replayed, then one item per stack value; an empty stack gives one status item.
// Throughput: one item at a time; the next item
// is taken while the last result waits in the output register.
// Reset (rst_n low, synchronous) empties the timeline; table and stack RAMs are not cleared.
`include "retroactive_stack_timeline_defines.svh"

module retroactive_stack_timeline #(
  parameter int unsigned TIMELINE_DEPTH = 32
) (
  input logic         clk,
  input logic         rst_n,
  rstl_in_if.sink     in_ch,
  rstl_out_if.source  out_ch
);

  import rstl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rstl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rstl_datapath #(.TIMELINE_DEPTH(TIMELINE_DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_stamp      (in_ch.stamp),
    .in_is_pop     (in_ch.is_pop),
    .in_push_value (in_ch.push_value),
    .out_ch        (out_ch)
  );

  `RSTL_ASSERT_NOW(a_res_free, cmd.op == DP_RES_LOAD, sts.out_free, "status item over a pending item")
  `RSTL_ASSERT_NOW(a_emit_free, cmd.op == DP_EMIT_LOAD, sts.out_free, "stack item over a pending item")
  `RSTL_ASSERT_NEXT(a_res_idle, cmd.op == DP_RES_LOAD, in_ch.ready, "no return to idle after status")
  `RSTL_ASSERT_NEXT(a_emit_idle, cmd.op == DP_EMIT_LOAD && sts.emit_last, in_ch.ready, "no idle after last")

endmodule

// ----- src/rstl_ram.sv -----
module rstl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/rstl_ctrl.sv -----
module rstl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_opcode,
  output logic            in_ready,
  output rstl_pkg::cmd_t  cmd,
  input  rstl_pkg::sts_t  sts
);

  import rstl_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = DP_LATCH;
          unique case (in_opcode)
            OP_INSERT: state_nxt = S_INS_RD;
            OP_DELETE: state_nxt = S_DEL_RD;
            OP_REPORT: state_nxt = S_REP_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        cmd.op    = DP_INS_INIT;
        state_nxt = sts.full ? S_RESULT : S_INS_SCAN;
      end
      S_INS_SCAN: begin
        cmd.op = DP_INS_STEP;
        if (sts.ins_stop) begin
          state_nxt = S_RESULT;
        end
      end
      S_DEL_RD: begin
        cmd.op    = DP_DEL_INIT;
        state_nxt = S_DEL_SCAN;
      end
      S_DEL_SCAN: begin
        cmd.op = DP_DEL_STEP;
        if (sts.scan_end) begin
          state_nxt = S_RESULT;
        end
      end
      S_REP_RD: begin
        cmd.op    = DP_REP_INIT;
        state_nxt = S_REP_SCAN;
      end
      S_REP_SCAN: begin
        cmd.op = DP_REP_STEP;
        if (sts.scan_end) begin
          state_nxt = sts.top_zero ? S_RESULT : S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (sts.out_free) begin
          cmd.op    = DP_EMIT_LOAD;
          state_nxt = sts.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.op    = DP_RES_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/rstl_datapath.sv -----
module rstl_datapath #(
  parameter int unsigned TIMELINE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rstl_pkg::cmd_t     cmd,
  output rstl_pkg::sts_t     sts,
  input  logic [15:0]        in_stamp,
  input  logic               in_is_pop,
  input  logic signed [31:0] in_push_value,
  rstl_out_if.source         out_ch
);

  import rstl_pkg::*;

  localparam int unsigned AW = (TIMELINE_DEPTH > 1) ? $clog2(TIMELINE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TIMELINE_DEPTH + 1);
  localparam int unsigned NW = (CW > RES_W) ? CW : RES_W;

  logic [15:0]        stamp_r;
  logic               is_pop_r;
  logic signed [31:0] value_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      top_r;
  logic               found_r;
  logic [1:0]         status_r;
  logic               empty_r;

  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_last_r;
  logic               out_empty_r;
  logic [1:0]         out_status_r;

  logic               tbl_we;
  logic [AW-1:0]      tbl_wa;
  entry_t             tbl_wd;
  logic [AW-1:0]      tbl_ra;
  logic [$bits(entry_t)-1:0] tbl_rd;
  entry_t             tbl_q;
  entry_t             new_ent;

  logic               stk_we;
  logic [AW-1:0]      stk_wa;
  logic [31:0]        stk_wd;
  logic [31:0]        stk_rd;

  logic [CW-1:0]      idx_p1;
  logic [CW-1:0]      idx_m1;
  logic [CW-1:0]      idx_m2;
  logic [CW-1:0]      count_m1;
  logic [NW-1:0]      top_ext;
  logic [NW-1:0]      emit_lim;
  logic               ins_stop;
  logic               scan_end;
  logic               out_free;
  logic               top_room;

  rstl_ram #(.WIDTH($bits(entry_t)), .DEPTH(TIMELINE_DEPTH)) u_tbl (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_wa),
    .wr_data (tbl_wd),
    .rd_addr (tbl_ra),
    .rd_data (tbl_rd)
  );

  rstl_ram #(.WIDTH(32), .DEPTH(TIMELINE_DEPTH)) u_stk (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_wa),
    .wr_data (stk_wd),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (stk_rd)
  );

  assign tbl_q    = entry_t'(tbl_rd);
  assign new_ent  = '{stamp: stamp_r, is_pop: is_pop_r,
                      value: is_pop_r ? 32'd0 : 32'(value_r)};
  assign idx_p1   = idx_r + CW'(1);
  assign idx_m1   = idx_r - CW'(1);
  assign idx_m2   = idx_r - CW'(2);
  assign count_m1 = count_r - CW'(1);
  assign ins_stop = (idx_r == '0) || (tbl_q.stamp <= stamp_r);
  assign scan_end = (idx_r == count_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign top_room = (top_r < CW'(TIMELINE_DEPTH));
  assign top_ext  = NW'(top_r);
  assign emit_lim = (top_ext > NW'(MAX_RESULTS)) ? NW'(MAX_RESULTS) : top_ext;

  assign sts.full      = (count_r == CW'(TIMELINE_DEPTH));
  assign sts.ins_stop  = ins_stop;
  assign sts.scan_end  = scan_end;
  assign sts.top_zero  = (top_r == '0);
  assign sts.out_free  = out_free;
  assign sts.emit_last = ((NW'(idx_r) + NW'(1)) == emit_lim);

  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = idx_r[AW-1:0];
    tbl_wd = tbl_q;
    tbl_ra = idx_p1[AW-1:0];
    stk_we = 1'b0;
    stk_wa = top_r[AW-1:0];
    stk_wd = tbl_q.value;
    unique case (cmd.op)
      DP_INS_INIT: begin
        tbl_ra = count_m1[AW-1:0];
      end
      DP_INS_STEP: begin
        tbl_we = 1'b1;
        tbl_wd = ins_stop ? new_ent : tbl_q;
        tbl_ra = idx_m2[AW-1:0];
      end
      DP_DEL_INIT, DP_REP_INIT: begin
        tbl_ra = '0;
      end
      DP_DEL_STEP: begin
        tbl_we = found_r && !scan_end;
        tbl_wa = idx_m1[AW-1:0];
      end
      DP_REP_STEP: begin
        stk_we = !scan_end && !tbl_q.is_pop && top_room;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      count_r     <= '0;
      top_r       <= '0;
      found_r     <= 1'b0;
      status_r    <= ST_OK;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready &&
          cmd.op != DP_EMIT_LOAD && cmd.op != DP_RES_LOAD) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        DP_LATCH: begin
          status_r <= ST_OK;
          empty_r  <= 1'b0;
          found_r  <= 1'b0;
        end
        DP_INS_INIT: begin
          idx_r <= count_r;
          if (count_r == CW'(TIMELINE_DEPTH)) begin
            status_r <= ST_FULL;
          end
        end
        DP_INS_STEP: begin
          if (ins_stop) begin
            count_r <= count_r + CW'(1);
          end else begin
            idx_r <= idx_m1;
          end
        end
        DP_DEL_INIT: begin
          idx_r   <= '0;
          found_r <= 1'b0;
        end
        DP_DEL_STEP: begin
          if (scan_end) begin
            if (found_r) begin
              count_r <= count_m1;
            end else begin
              status_r <= ST_MISSING;
            end
          end else begin
            idx_r <= idx_p1;
            if (!found_r && tbl_q.stamp == stamp_r) begin
              found_r <= 1'b1;
            end
          end
        end
        DP_REP_INIT: begin
          idx_r <= '0;
          top_r <= '0;
        end
        DP_REP_STEP: begin
          if (scan_end) begin
            empty_r <= (top_r == '0);
            idx_r   <= '0;
          end else begin
            idx_r <= idx_p1;
            if (tbl_q.is_pop) begin
              if (top_r != '0) begin
                top_r <= top_r - CW'(1);
              end
            end else if (top_room) begin
              top_r <= top_r + CW'(1);
            end
          end
        end
        DP_EMIT_LOAD: begin
          out_valid_r <= 1'b1;
          idx_r       <= idx_p1;
        end
        DP_RES_LOAD: begin
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LATCH: begin
        stamp_r  <= in_stamp;
        is_pop_r <= in_is_pop;
        value_r  <= in_push_value;
      end
      DP_EMIT_LOAD: begin
        out_value_r  <= $signed(stk_rd);
        out_last_r   <= sts.emit_last;
        out_empty_r  <= 1'b0;
        out_status_r <= ST_OK;
      end
      DP_RES_LOAD: begin
        out_value_r  <= '0;
        out_last_r   <= 1'b1;
        out_empty_r  <= empty_r;
        out_status_r <= status_r;
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.stack_value = out_value_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.empty_res   = out_empty_r;
  assign out_ch.status      = out_status_r;

endmodule
